### sv/dad_pkg.sv
// Shared types, constants and calendar helpers for the date_add_days block.
// Depends on nothing; the top level uses it through scoped names.
`default_nettype none

package dad_pkg;

   localparam int unsigned DayWidth   = 5;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth  = 14;
   localparam int unsigned OrdWidth   = 9;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [OrdWidth-1:0] DaysToAddReset = 9'd100;
   localparam logic [OrdWidth-1:0] MaxDaysToAdd   = 9'd365;
   localparam logic [OrdWidth-1:0] LeapYearLen    = 9'd366;
   localparam logic [OrdWidth-1:0] CommonYearLen  = 9'd365;

   // register index, taken from paddr above the byte offset
   localparam logic RegDaysToAdd = 1'b0;

   // 25 * Inv25 == 1 modulo 2**14; y is a multiple of 25 exactly when
   // y * Inv25 (mod 2**14) does not exceed (2**14 - 1) / 25
   localparam logic [YearWidth-1:0] Inv25      = 14'd7209;
   localparam logic [YearWidth-1:0] Div25Limit = 14'd655;

   typedef struct packed {
      logic [DayWidth-1:0]   day_in;
      logic [MonthWidth-1:0] month_in;
      logic [YearWidth-1:0]  year_in;
   } req_payload_type;

   typedef struct packed {
      logic [OrdWidth-1:0]   start_day_of_year;
      logic                  start_is_leap;
      logic [DayWidth-1:0]   end_day;
      logic [MonthWidth-1:0] end_month;
      logic [YearWidth-1:0]  end_year;
      logic [OrdWidth-1:0]   end_day_of_year;
      logic                  end_is_leap;
   } rsp_payload_type;

   // days before the first of a month in a common year, month index 0 = January
   function automatic logic [OrdWidth-1:0] days_before(input logic [MonthWidth-1:0] idx);
      logic [OrdWidth-1:0] d;
      case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         default: d = 9'd334;
      endcase
      return d;
   endfunction

   // Gregorian rule: divisible by 4, and either by 16 or not by 25
   function automatic logic is_leap(input logic [YearWidth-1:0] y);
      logic [2*YearWidth-1:0] prod;
      logic div4, div16, div25;
      prod  = {{YearWidth{1'b0}}, y} * {{YearWidth{1'b0}}, Inv25};
      div4  = (y[1:0] == 2'd0);
      div16 = (y[3:0] == 4'd0);
      div25 = (prod[YearWidth-1:0] <= Div25Limit);
      return div4 && (div16 || !div25);
   endfunction

endpackage

`default_nettype wire

### sv/date_add_days.sv
// date_add_days top level: four-stage date pipeline and its APB register.
// Depends on dad_pkg for payload types, the month table and the leap test.
//
// Use: each transfer on the req_ channel carries a Gregorian date (day, month,
// year). The block adds the days_to_add register (0 to 365, writes whose bits
// 8:0 exceed 365 saturate) and returns on the rsp_ channel the start ordinal
// and leap flag, the resulting date, its ordinal and its leap flag, one result
// per date.
// Throughput is one date per clock while rsp_ready is high: every stage holds
// a valid bit, and a stage loads when it is empty or its contents move on, so
// bubbles close up.
// Stages: leap tests of the year and the next year (one 14-bit multiply each)
// and the table lookup; ordinal add and year carry; month compares; day
// subtract into the output register.
// When the receiver holds rsp_ready low, the output register holds its result
// and the stages behind it fill up; req_ready falls once all four are full.
// Reset empties the pipeline and sets days_to_add to 100.
// The register sits at byte address 0 of the APB port; pready is always high.
`default_nettype none

module date_add_days (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_ready,
   input  wire  dad_pkg::req_payload_type         req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_ready,
   output dad_pkg::rsp_payload_type               rsp_data,
   input  wire                                    csr_psel,
   input  wire                                    csr_penable,
   input  wire                                    csr_pwrite,
   input  wire  [dad_pkg::CsrAddrWidth-1:0]       csr_paddr,
   input  wire  [dad_pkg::CsrDataWidth-1:0]       csr_pwdata,
   output logic [dad_pkg::CsrDataWidth-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   localparam int unsigned OW = dad_pkg::OrdWidth;
   localparam int unsigned MW = dad_pkg::MonthWidth;
   localparam int unsigned YW = dad_pkg::YearWidth;
   localparam int unsigned DW = dad_pkg::DayWidth;

   // ---------------- configuration register ----------------
   logic [OW-1:0] days_ff, days_in;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == dad_pkg::RegDaysToAdd);

   always_comb begin
      days_in = days_ff;
      if (csr_write) begin
         if (csr_pwdata[OW-1:0] > dad_pkg::MaxDaysToAdd) begin
            days_in = dad_pkg::MaxDaysToAdd;
         end else begin
            days_in = csr_pwdata[OW-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == dad_pkg::RegDaysToAdd) begin
         csr_prdata[OW-1:0] = days_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         days_ff <= dad_pkg::DaysToAddReset;
      end else begin
         days_ff <= days_in;
      end
   end

   // ---------------- stage enables ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4       = !v4_ff || rsp_ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: month clamp, table, leap tests ----------------
   logic [OW-1:0] s1_base_ff, s1_base_in;
   logic          s1_after_feb_ff, s1_after_feb_in;
   logic          s1_leap_ff, s1_leap_in;
   logic          s1_leap_next_ff, s1_leap_next_in;
   logic [YW-1:0] s1_year_ff, s1_year_next_ff, s1_year_next_in;
   logic [MW-1:0] month_idx;

   always_comb begin
      if (req_data.month_in == '0) begin
         month_idx = '0;
      end else if (req_data.month_in > MW'(12)) begin
         month_idx = MW'(11);
      end else begin
         month_idx = req_data.month_in - MW'(1);
      end
      s1_base_in      = dad_pkg::days_before(month_idx) + OW'(req_data.day_in);
      s1_after_feb_in = (month_idx > MW'(1));
      s1_year_next_in = req_data.year_in + YW'(1);
      s1_leap_in      = dad_pkg::is_leap(req_data.year_in);
      s1_leap_next_in = dad_pkg::is_leap(s1_year_next_in);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_base_ff      <= s1_base_in;
         s1_after_feb_ff <= s1_after_feb_in;
         s1_leap_ff      <= s1_leap_in;
         s1_leap_next_ff <= s1_leap_next_in;
         s1_year_ff      <= req_data.year_in;
         s1_year_next_ff <= s1_year_next_in;
      end
   end

   // ---------------- stage 2: start ordinal, add, year carry ----------------
   logic [OW-1:0] s2_start_ff, s2_start_in;
   logic          s2_start_leap_ff;
   logic [OW-1:0] s2_sum_ff, s2_sum_in;
   logic [YW-1:0] s2_year_ff, s2_year_in;
   logic          s2_leap_ff, s2_leap_in;
   logic [OW:0]   sum_wide;
   logic [OW:0]   year_len;

   always_comb begin
      s2_start_in = s1_base_ff + OW'(s1_leap_ff && s1_after_feb_ff);
      sum_wide    = {1'b0, s2_start_in} + {1'b0, days_ff};
      year_len    = s1_leap_ff ? {1'b0, dad_pkg::LeapYearLen} : {1'b0, dad_pkg::CommonYearLen};
      if (sum_wide > year_len) begin
         s2_sum_in  = OW'(sum_wide - year_len);
         s2_year_in = s1_year_next_ff;
         s2_leap_in = s1_leap_next_ff;
      end else begin
         s2_sum_in  = sum_wide[OW-1:0];
         s2_year_in = s1_year_ff;
         s2_leap_in = s1_leap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_start_ff      <= s2_start_in;
         s2_start_leap_ff <= s1_leap_ff;
         s2_sum_ff        <= s2_sum_in;
         s2_year_ff       <= s2_year_in;
         s2_leap_ff       <= s2_leap_in;
      end
   end

   // ---------------- stage 3: month search ----------------
   logic [MW-1:0] s3_month_ff, s3_month_in;
   logic [OW-1:0] s3_start_ff, s3_sum_ff;
   logic          s3_start_leap_ff, s3_leap_ff;
   logic [YW-1:0] s3_year_ff;
   logic [10:0]   past_end;

   always_comb begin
      // past_end[i]: the ordinal lies beyond the last day of month i
      for (int i = 0; i < 11; i++) begin
         past_end[i] = s2_sum_ff > (dad_pkg::days_before(MW'(i + 1))
                                    + OW'(s2_leap_ff && (i >= 1)));
      end
      s3_month_in = MW'(11);
      for (int i = 10; i >= 0; i--) begin
         if (!past_end[i]) s3_month_in = MW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_month_ff      <= s3_month_in;
         s3_start_ff      <= s2_start_ff;
         s3_start_leap_ff <= s2_start_leap_ff;
         s3_sum_ff        <= s2_sum_ff;
         s3_year_ff       <= s2_year_ff;
         s3_leap_ff       <= s2_leap_ff;
      end
   end

   // ---------------- stage 4: day of month, output register ----------------
   dad_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [OW-1:0]            day_wide;

   always_comb begin
      day_wide = s3_sum_ff - dad_pkg::days_before(s3_month_ff)
                 - OW'(s3_leap_ff && (s3_month_ff > MW'(1)));
      rsp_in.start_day_of_year = s3_start_ff;
      rsp_in.start_is_leap     = s3_start_leap_ff;
      rsp_in.end_day           = day_wide[DW-1:0];
      rsp_in.end_month         = s3_month_ff + MW'(1);
      rsp_in.end_year          = s3_year_ff;
      rsp_in.end_day_of_year   = s3_sum_ff;
      rsp_in.end_is_leap       = s3_leap_ff;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire
